[hdl/ipv4_header_builder_top_assert.svh]
// Assertion macros used by the assertion checker of the IPv4 header builder.
`ifndef IPV4_HEADER_BUILDER_TOP_ASSERT_SVH
`define IPV4_HEADER_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on the rising edge, quiet while in reset.
`define IHB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on the rising edge, quiet while in reset.
`define IHB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ihb_pkg.sv]
// Package with constants and register codes of the IPv4 header builder.
package ihb_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned ProtoW  = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned SumW     = 19;

  localparam logic [LenW-1:0]  MaxPayload = 16'd65515;
  localparam logic [LenW-1:0]  HdrBytes   = 16'd20;
  localparam logic [IdxW-1:0]  LastIdx    = 3'd4;
  localparam logic [AddrW-1:0] MaskReset  = 32'hFFFF_FF00;

  // Fixed header parts.
  localparam logic [15:0] VerIhlTos = 16'h4500;
  localparam logic [31:0] IdFlags   = 32'h0001_4000;
  localparam logic [7:0]  Ttl       = 8'h40;
  // Sum of all constant 16-bit header halves: 0x4500 + 0x0001 + 0x4000 + 0x4000.
  localparam logic [SumW-1:0] ConstSum = 19'h0C501;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_LOCAL_IP    = 2'd0,
    CFG_SUBNET_MASK = 2'd1,
    CFG_GATEWAY_IP  = 2'd2
  } cfg_idx_e;

  typedef enum logic [IdxW-1:0] {
    WORD_LEN   = 3'd0,
    WORD_ID    = 3'd1,
    WORD_CSUM  = 3'd2,
    WORD_SRC   = 3'd3,
    WORD_DST   = 3'd4
  } word_idx_e;

endpackage

[hdl/ipv4_header_builder_top.sv]
// IPv4 header builder: three-stage header pipeline and a five-word output serializer.
//
// Input channel s_axis carries one request per item: destination address,
// protocol number and payload length. Output channel m_axis carries five
// items per request, the header words 0 to 4 in wire order, each tagged with
// its index and the next-hop address; tlast marks word 4.
// The configuration port writes local_ip, subnet_mask and gateway_ip by index;
// indexes above 2 are ignored. Write it only while no request is in flight.
// An accepted request passes stages A, B and C into the serializer, which shows
// word 0 first; later words come one per cycle while m_axis_tready is high.
// The output channel, which moves one word per cycle while m_axis_tready is high,
// sets the request rate. The three pipeline stages (length saturation,
// checksum sum and next-hop select, fold) keep taking requests while the
// serializer drains, so up to four requests can be held inside.
// Reset empties the pipeline and loads the register reset values
// (subnet_mask 255.255.255.0, the others zero).
// When the receiver stalls, the current word holds steady, the pipeline fills
// up behind it, and s_axis_tready drops once every stage is occupied.
module ipv4_header_builder_top
  import ihb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [AddrW-1:0]    cfg_wdata_i,
  // Request channel.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: dest_ip [31:0], proto_num [39:32], payload_length [55:40].
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Header word channel.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: header_word [31:0], word_index [34:32], next_hop_ip [66:35], zero [71:67].
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  // Configuration registers.
  logic [AddrW-1:0] local_ip_q, subnet_mask_q, gateway_ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q    <= '0;
      subnet_mask_q <= MaskReset;
      gateway_ip_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LOCAL_IP:    local_ip_q    <= cfg_wdata_i;
        CFG_SUBNET_MASK: subnet_mask_q <= cfg_wdata_i;
        CFG_GATEWAY_IP:  gateway_ip_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input field split.
  logic [AddrW-1:0]  in_dst;
  logic [ProtoW-1:0] in_proto;
  logic [LenW-1:0]   in_plen, in_plen_sat;

  assign in_dst      = s_axis_tdata[31:0];
  assign in_proto    = s_axis_tdata[39:32];
  assign in_plen     = s_axis_tdata[55:40];
  assign in_plen_sat = (in_plen > MaxPayload) ? MaxPayload : in_plen;

  // Stage handshakes, back to front.
  logic a_vld_q, b_vld_q, c_vld_q, ser_vld_q;
  logic a_rdy, b_rdy, c_rdy, ser_load, ser_last_take;
  logic [IdxW-1:0] idx_q;

  assign ser_last_take = ser_vld_q && m_axis_tready && (idx_q == LastIdx);
  assign ser_load      = c_vld_q && (!ser_vld_q || ser_last_take);
  assign c_rdy         = !c_vld_q || ser_load;
  assign b_rdy         = !b_vld_q || c_rdy;
  assign a_rdy         = !a_vld_q || b_rdy;
  assign s_axis_tready = a_rdy;

  // Stage A: saturated total length.
  logic [AddrW-1:0]  a_dst_q;
  logic [ProtoW-1:0] a_proto_q;
  logic [LenW-1:0]   a_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_rdy) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && s_axis_tvalid) begin
      a_dst_q   <= in_dst;
      a_proto_q <= in_proto;
      a_total_q <= in_plen_sat + HdrBytes;
    end
  end

  // Stage B: raw ones' complement sum and subnet test.
  logic [AddrW-1:0]  b_dst_q, b_hop_q;
  logic [ProtoW-1:0] b_proto_q;
  logic [LenW-1:0]   b_total_q;
  logic [SumW-1:0]   b_sum_q, b_sum_d;
  logic [AddrW-1:0]  b_hop_d;

  assign b_sum_d = ConstSum + SumW'(a_total_q) + SumW'(a_proto_q)
                 + SumW'(local_ip_q[31:16]) + SumW'(local_ip_q[15:0])
                 + SumW'(a_dst_q[31:16]) + SumW'(a_dst_q[15:0]);
  assign b_hop_d = ((a_dst_q & subnet_mask_q) != (local_ip_q & subnet_mask_q))
                 ? gateway_ip_q : a_dst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_rdy) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_vld_q) begin
      b_dst_q   <= a_dst_q;
      b_proto_q <= a_proto_q;
      b_total_q <= a_total_q;
      b_sum_q   <= b_sum_d;
      b_hop_q   <= b_hop_d;
    end
  end

  // Stage C: end-around carry fold and complement.
  logic [AddrW-1:0]  c_dst_q, c_hop_q;
  logic [ProtoW-1:0] c_proto_q;
  logic [LenW-1:0]   c_total_q, c_csum_q;
  logic [16:0]       fold1;
  logic [15:0]       fold2;

  assign fold1 = {1'b0, b_sum_q[15:0]} + 17'(b_sum_q[18:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (c_rdy) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy && b_vld_q) begin
      c_dst_q   <= b_dst_q;
      c_proto_q <= b_proto_q;
      c_total_q <= b_total_q;
      c_csum_q  <= ~fold2;
      c_hop_q   <= b_hop_q;
    end
  end

  // Serializer: holds one header and steps through its five words.
  logic [AddrW-1:0]  s_dst_q, s_hop_q;
  logic [ProtoW-1:0] s_proto_q;
  logic [LenW-1:0]   s_total_q, s_csum_q;
  logic [AddrW-1:0]  word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (ser_load) begin
      ser_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (ser_last_take) begin
      ser_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (ser_vld_q && m_axis_tready) begin
      idx_q     <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      s_dst_q   <= c_dst_q;
      s_proto_q <= c_proto_q;
      s_total_q <= c_total_q;
      s_csum_q  <= c_csum_q;
      s_hop_q   <= c_hop_q;
    end
  end

  always_comb begin
    case (idx_q)
      WORD_LEN:  word = {VerIhlTos, s_total_q};
      WORD_ID:   word = IdFlags;
      WORD_CSUM: word = {Ttl, s_proto_q, s_csum_q};
      WORD_SRC:  word = local_ip_q;
      WORD_DST:  word = s_dst_q;
      default:   word = '0;
    endcase
  end

  assign m_axis_tvalid = ser_vld_q;
  assign m_axis_tdata  = {5'd0, s_hop_q, idx_q, word};
  assign m_axis_tlast  = (idx_q == LastIdx);

endmodule

[hdl/ihb_assert_chk.sv]
// Port-level assertion checker for the IPv4 header builder, bound to its top level.
`include "ipv4_header_builder_top_assert.svh"

module ihb_assert_chk
  import ihb_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  logic            out_take;
  logic [IdxW-1:0] out_idx;
  logic [AddrW-1:0] out_hop;

  assign out_take = m_axis_tvalid && m_axis_tready;
  assign out_idx  = m_axis_tdata[34:32];
  assign out_hop  = m_axis_tdata[66:35];

  `IHB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled header word changed")
  `IHB_ASSERT_IMP(a_last_idx, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == (out_idx == LastIdx), "tlast does not match word index four")
  `IHB_ASSERT_NXT(a_idx_step, clk_i, rst_ni, out_take && !m_axis_tlast, m_axis_tvalid && (out_idx == $past(out_idx) + 3'd1), "header words out of sequence")
  `IHB_ASSERT_NXT(a_hop_same, clk_i, rst_ni, out_take && !m_axis_tlast, out_hop == $past(out_hop), "next hop changed within a header")
  `IHB_ASSERT_IMP(a_word_one, clk_i, rst_ni, m_axis_tvalid && (out_idx == 3'd1), m_axis_tdata[31:0] == IdFlags, "identification word is wrong")

endmodule

bind ipv4_header_builder_top ihb_assert_chk u_ihb_assert_chk (.*);

[sim/ihb_header_checker.sv]
// Checker that predicts the five header words of each request and compares them on m_axis.
`timescale 1ns / 100ps

module ihb_header_checker
  import ihb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [AddrW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // tdata: dest_ip, proto_num, payload_length.
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: header_word, word_index, next_hop_ip, zero padding.
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam logic [15:0] PayloadCap   = 16'd65515;
  localparam logic [15:0] HeaderBytes  = 16'd20;
  localparam logic [15:0] VersionTos   = 16'h4500;
  localparam logic [31:0] IdentFlags   = 32'h0001_4000;
  localparam logic [7:0]  TimeToLive   = 8'h40;
  localparam logic [31:0] MaskAtReset  = 32'hFFFF_FF00;
  localparam int          WordsPerHdr  = 5;

  typedef struct packed {
    logic [31:0]     word;
    logic [IdxW-1:0] index;
    logic [31:0]     hop;
    logic            last;
  } hdr_word_t;

  hdr_word_t   header_words_q[$];
  logic [31:0] local_addr;
  logic [31:0] net_mask;
  logic [31:0] gw_addr;
  int          fails = 0;

  assign fail_count_o = fails;

  task automatic queue_header(input logic [31:0] dst, input logic [7:0] proto,
                              input logic [15:0] plen);
    logic [15:0] len_sat;
    logic [31:0] w[WordsPerHdr];
    logic [31:0] acc;
    logic [31:0] hop;
    hdr_word_t   item;
    int          k;
    len_sat = (plen > PayloadCap) ? PayloadCap : plen;
    w[0] = {VersionTos, len_sat + HeaderBytes};
    w[1] = IdentFlags;
    w[2] = {TimeToLive, proto, 16'h0000};
    w[3] = local_addr;
    w[4] = dst;
    acc = 32'd0;
    for (k = 0; k < WordsPerHdr; k++) acc = acc + w[k][31:16] + w[k][15:0];
    // Fold the carries back in until the sum fits in 16 bits.
    while (acc[31:16] != 16'd0) acc = acc[15:0] + acc[31:16];
    w[2][15:0] = ~acc[15:0];
    hop = ((dst & net_mask) != (local_addr & net_mask)) ? gw_addr : dst;
    for (k = 0; k < WordsPerHdr; k++) begin
      item.word  = w[k];
      item.index = k[IdxW-1:0];
      item.hop   = hop;
      item.last  = (k == WordsPerHdr - 1);
      header_words_q.push_back(item);
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_val, act_val);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hdr_word_t exp_item;
    if (!rst_ni) begin
      local_addr = 32'd0;
      net_mask   = MaskAtReset;
      gw_addr    = 32'd0;
      header_words_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_LOCAL_IP:    local_addr = cfg_wdata_i;
          CFG_SUBNET_MASK: net_mask   = cfg_wdata_i;
          CFG_GATEWAY_IP:  gw_addr    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (header_words_q.size() == 0) begin
          $display("%0t: unexpected header item: expected none, actual %h", $time,
                   m_axis_tdata);
          fails++;
        end else begin
          exp_item = header_words_q.pop_front();
          compare_field("header_word", exp_item.word, m_axis_tdata[31:0]);
          compare_field("word_index", {29'd0, exp_item.index}, {29'd0, m_axis_tdata[34:32]});
          compare_field("next_hop_ip", exp_item.hop, m_axis_tdata[66:35]);
          compare_field("last_word", {31'd0, exp_item.last}, {31'd0, m_axis_tlast});
          compare_field("padding", 32'd0, {27'd0, m_axis_tdata[71:67]});
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        queue_header(s_axis_tdata[31:0], s_axis_tdata[39:32], s_axis_tdata[55:40]);
    end
    pending_o = header_words_q.size();
  end

endmodule

[sim/testbench.sv]
// Top of the IPv4 header builder testbench: clock, reset, requests, receiver and verdict.
`timescale 1ns / 100ps

module testbench;
  import ihb_pkg::*;

  localparam logic [CfgAddrW-1:0] CfgUnusedIdx = 2'd3;
  localparam int SettleCycles = 8;
  localparam int HoldOffCycles = 120;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [AddrW-1:0]    cfg_wdata;
  logic                s_valid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_data;
  logic                m_axis_tvalid;
  logic                m_ready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  int                  fail_count;
  int                  pending;

  int                  send_idle = 0;
  int                  recv_idle = 0;
  int                  hold_req  = 0;
  logic [31:0]         cur_local = 32'd0;
  logic [31:0]         cur_mask  = 32'hFFFF_FF00;

  ipv4_header_builder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ihb_header_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_request(input logic [31:0] dst, input logic [7:0] proto,
                              input logic [15:0] plen);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {plen, proto, dst};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
  endtask

  // The block must be idle here; the write to the unused index must change nothing.
  task automatic apply_config(input logic [31:0] local_ip, input logic [31:0] mask,
                              input logic [31:0] gateway);
    write_reg(CFG_LOCAL_IP, local_ip);
    write_reg(CFG_SUBNET_MASK, mask);
    write_reg(CFG_GATEWAY_IP, gateway);
    write_reg(CfgUnusedIdx, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    cur_local = local_ip;
    cur_mask  = mask;
  endtask

  task automatic drain;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int          phase;
    int          prefix;
    logic [31:0] dst;
    logic [15:0] plen;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 36;
    recv_idle = 54;
    // Registers at their reset values first.
    send_request(32'h0000_0000, 8'h00, 16'd0);
    send_request(32'hFFFF_FFFF, 8'hFF, 16'd65515);
    send_request(32'h0000_00FF, 8'd6, 16'd65516);
    drain();

    apply_config(32'hC0A8_0105, 32'hFFFF_FF00, 32'hC0A8_01FE);
    send_request(32'hC0A8_0142, 8'd17, 16'd1472);
    send_request(32'h0808_0808, 8'd6, 16'd65535);
    send_request(32'hC0A8_01FF, 8'd1, 16'd0);
    send_request(32'h0000_0000, 8'hFF, 16'd20);
    send_request(32'hFFFF_FFFF, 8'h00, 16'd65515);
    drain();

    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 8'hFF, 16'd65535);
    send_request(32'hFFFF_FFFE, 8'h11, 16'd0);
    send_request(32'h0000_0000, 8'h2A, 16'hAAAA);
    drain();

    // A zero mask puts every destination in the local subnet.
    apply_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(32'hA5A5_A5A5, 8'hA5, 16'h5555);
    send_request(32'h5A5A_5A5A, 8'h5A, 16'hFFEB);
    drain();

    apply_config(32'h0A00_0001, 32'hFF00_0000, 32'h0A00_00FE);
    send_request(32'h0A12_3456, 8'd89, 16'd576);
    send_request(32'h0B00_0001, 8'd50, 16'd9000);
    drain();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 36; recv_idle = 54; end
        1: begin send_idle = 54; recv_idle = 36; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      prefix = $urandom_range(32);
      apply_config($urandom,
                   (prefix == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - prefix)),
                   $urandom);
      // With no idling the receiver stops for a long stretch so the pipeline fills.
      if (phase == 2) hold_req++;
      repeat (28) begin
        case ($urandom_range(3))
          0: dst = (cur_local & cur_mask) | ($urandom & ~cur_mask);
          3: dst = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
          default: dst = $urandom;
        endcase
        case ($urandom_range(7))
          0: plen = 16'd0;
          1: plen = 16'd65515 + 16'($urandom_range(20));
          default: plen = 16'($urandom_range(65535));
        endcase
        send_request(dst, 8'($urandom_range(255)), plen);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
